// File: hdl/grpl_pkg.sv
// Shared types and constants for the game ring ply locator.
// No dependencies; imported by the top level.
package grpl_pkg;

  localparam int unsigned CAP_W       = 9;
  localparam int unsigned PLIES_IN_W  = 10;
  localparam int unsigned OFFSET_W    = 17;
  localparam int unsigned LIVE_W      = 18;
  localparam int unsigned GIDX_W      = 48;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Input item kinds carried on tuser.
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_LOCATE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  // Result item; the first field sits in the highest bits.
  typedef struct packed {
    logic              out_of_range;
    logic [LIVE_W-1:0] live_plies;
    logic [9:0]        evicted_plies;
    logic              evicted;
    logic [8:0]        ply_index;
    logic [7:0]        slot;
  } result_t;

endpackage

// File: hdl/grpl_slot_table.sv
// Slot table memory: start index and ply count for each game slot.
// One write port and one registered read port; no dependencies.
module grpl_slot_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 58
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/game_ring_ply_locator.sv
// Game ring ply locator: ring of game slots with global ply numbering.
// Add: the result follows one table read (on eviction) and one table update.
// Locate: the slots in use are scanned one per cycle through the table read
// port until one holds the target ply; out-of-range offsets skip the scan.
// One item at a time: s_axis_tready is high only while idle.
// Reset (rst, synchronous) clears counters and sets capacity to 256; the table is not cleared.
module game_ring_ply_locator
  import grpl_pkg::*;
#(
  parameter int unsigned SLOT_COUNT     = 256,
  parameter int unsigned MAX_GAME_PLIES = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // game_plies[9:0], sample_offset[26:10]
  input  logic                  s_axis_tuser,   // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // slot, ply_index, evicted, evicted_plies,
                                                // live_plies, out_of_range
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_data
);

  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned LW = $clog2(MAX_GAME_PLIES + 1);
  localparam int unsigned DW = GIDX_W + LW;

  state_t              state;
  logic [CAP_W-1:0]    capacity;
  logic [CW-1:0]       slots_filled;
  logic [SW-1:0]       oldest_slot;
  logic [GIDX_W-1:0]   removed_base;
  logic [LIVE_W-1:0]   live_count;

  logic [SW-1:0]       op_slot;
  logic [SW-1:0]       op_oldest_next;
  logic                op_evict;
  logic [LW-1:0]       op_plies;
  logic [GIDX_W-1:0]   base_sum;
  logic [CW-1:0]       iss;
  logic                pend;
  logic [SW-1:0]       pidx;
  result_t             res;
  result_t             res_init;
  result_t             out_res;
  logic                out_valid;
  logic                fin_go;

  logic                in_xfer;
  logic                kind;
  logic [PLIES_IN_W-1:0] game_plies;
  logic [OFFSET_W-1:0] sample_offset;
  logic [CW-1:0]       cap_eff;
  logic                add_evict;
  logic [SW-1:0]       add_slot;
  logic [CW-1:0]       slot_inc;
  logic [SW-1:0]       oldest_next;
  logic [LW-1:0]       plies_sat;
  logic [GIDX_W-1:0]   acc_sum;

  logic                tbl_we;
  logic                tbl_re;
  logic [SW-1:0]       tbl_raddr;
  logic [DW-1:0]       tbl_rdata;
  logic [GIDX_W-1:0]   rd_start;
  logic [LW-1:0]       rd_len;
  logic [LW-1:0]       old_len;
  logic                scan_rd;
  logic [GIDX_W-1:0]   ply_delta;
  logic                hit;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign kind          = s_axis_tuser;
  assign game_plies    = s_axis_tdata[PLIES_IN_W-1:0];
  assign sample_offset = s_axis_tdata[PLIES_IN_W +: OFFSET_W];
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_res};
  assign fin_go        = (state == S_FIN) && (!out_valid || m_axis_tready);

  // Capacity zero acts as one; values beyond the table size are clipped.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity) > SLOT_COUNT) begin
      cap_eff = CW'(SLOT_COUNT);
    end else begin
      cap_eff = CW'(capacity);
    end
  end

  // A stale oldest pointer (capacity lowered) evicts slot zero.
  always_comb begin
    add_evict = (slots_filled >= cap_eff);
    if (!add_evict) begin
      add_slot = slots_filled[SW-1:0];
    end else if (CW'(oldest_slot) < cap_eff) begin
      add_slot = oldest_slot;
    end else begin
      add_slot = '0;
    end
    slot_inc    = CW'(add_slot) + CW'(1);
    oldest_next = (slot_inc >= cap_eff) ? '0 : slot_inc[SW-1:0];
    if (32'(game_plies) > MAX_GAME_PLIES) begin
      plies_sat = LW'(MAX_GAME_PLIES);
    end else begin
      plies_sat = LW'(game_plies);
    end
  end

  // Starting result of an accepted item; later steps fill in the remaining fields.
  always_comb begin
    res_init              = '0;
    res_init.live_plies   = live_count;
    res_init.out_of_range = (kind == KIND_LOCATE) &&
                            (LIVE_W'(sample_offset) >= live_count);
  end

  // One wide adder serves both kinds: next start index for add, target ply for locate.
  assign acc_sum = removed_base +
                   ((kind == KIND_LOCATE) ? GIDX_W'(sample_offset) : GIDX_W'(live_count));

  assign rd_start  = tbl_rdata[DW-1 -: GIDX_W];
  assign rd_len    = tbl_rdata[LW-1:0];
  assign old_len   = op_evict ? rd_len : '0;
  assign scan_rd   = (state == S_SCAN) && (iss < slots_filled);
  assign ply_delta = base_sum - rd_start;
  assign hit       = pend && (ply_delta < GIDX_W'(rd_len));

  assign tbl_we    = (state == S_ADD);
  assign tbl_re    = scan_rd || (in_xfer && (kind == KIND_ADD) && add_evict);
  assign tbl_raddr = (state == S_SCAN) ? iss[SW-1:0] : add_slot;

  grpl_slot_table #(
    .DEPTH (SLOT_COUNT),
    .AW    (SW),
    .DW    (DW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (op_slot),
    .wdata ({base_sum, op_plies}),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      capacity     <= CAP_RESET;
      slots_filled <= '0;
      oldest_slot  <= '0;
      removed_base <= '0;
      live_count   <= '0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            base_sum       <= acc_sum;
            op_slot        <= add_slot;
            op_evict       <= add_evict;
            op_oldest_next <= oldest_next;
            op_plies       <= plies_sat;
            iss            <= '0;
            pend           <= 1'b0;
            res            <= res_init;
            if (kind == KIND_ADD) begin
              state <= S_ADD;
            end else if (res_init.out_of_range) begin
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_ADD: begin
          if (op_evict) begin
            removed_base <= removed_base + GIDX_W'(old_len);
            oldest_slot  <= op_oldest_next;
          end else begin
            slots_filled <= slots_filled + CW'(1);
          end
          live_count        <= live_count - LIVE_W'(old_len) + LIVE_W'(op_plies);
          res.slot          <= 8'(op_slot);
          res.evicted       <= op_evict;
          res.evicted_plies <= 10'(old_len);
          res.live_plies    <= live_count - LIVE_W'(old_len) + LIVE_W'(op_plies);
          state             <= S_FIN;
        end
        S_SCAN: begin
          // Reads are pipelined: one slot is issued while the previous one is compared.
          pend <= scan_rd;
          pidx <= iss[SW-1:0];
          if (scan_rd) begin
            iss <= iss + CW'(1);
          end
          if (hit) begin
            res.slot      <= 8'(pidx);
            res.ply_index <= ply_delta[8:0];
            state         <= S_FIN;
          end else if (!pend && !scan_rd) begin
            res.out_of_range <= 1'b1;
            state            <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            out_res <= res;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: dv/game_ring_ply_locator_tb.sv
// Self-checking testbench for the game ring ply locator: add and locate items are
// predicted against a local copy of the slot ring and compared field by field.
// Depends on grpl_pkg and game_ring_ply_locator from hdl/.
module game_ring_ply_locator_tb
  import grpl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = 256;
  localparam int unsigned MAX_PLIES   = 512;
  localparam int unsigned RES_W       = $bits(result_t);
  localparam int unsigned HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // game_plies[9:0], sample_offset[26:10]
  logic                  s_axis_tuser = 1'b0;  // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // slot, ply_index, evicted, evicted_plies,
                                               // live_plies, out_of_range
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data = '0;

  // Local copy of the ring.
  logic [GIDX_W-1:0]     ring_start [SLOTS];
  logic [PLIES_IN_W-1:0] ring_len [SLOTS];
  int unsigned           ring_filled = 0;
  int unsigned           ring_oldest = 0;
  logic [GIDX_W-1:0]     ring_removed = '0;
  logic [LIVE_W-1:0]     ring_live = '0;
  logic [CAP_W-1:0]      ring_capacity = CAP_RESET;

  result_t     ring_results_due [$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  game_ring_ply_locator #(
    .SLOT_COUNT    (SLOTS),
    .MAX_GAME_PLIES(MAX_PLIES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** game_ring_ply_locator: FAILED **");
    $finish;
  end

  // Applies one item to the local ring and returns the result it must produce.
  function automatic result_t ring_apply_item(input logic kind,
                                              input logic [PLIES_IN_W-1:0] plies,
                                              input logic [OFFSET_W-1:0] offset);
    result_t               r;
    int unsigned           cap;
    int unsigned           slot;
    int unsigned           i;
    logic [PLIES_IN_W-1:0] len_in;
    logic [PLIES_IN_W-1:0] old_len;
    logic [GIDX_W-1:0]     first_ply;
    logic [GIDX_W-1:0]     gidx;
    logic [GIDX_W-1:0]     delta;
    r = '0;
    cap = (ring_capacity == 0) ? 1 : ((ring_capacity > SLOTS) ? SLOTS : ring_capacity);
    if (kind == KIND_ADD) begin
      len_in = (plies > MAX_PLIES) ? PLIES_IN_W'(MAX_PLIES) : plies;
      first_ply = ring_removed + GIDX_W'(ring_live);
      old_len = '0;
      if (ring_filled < cap) begin
        slot = ring_filled;
        ring_filled++;
      end else begin
        // A pointer left beyond a lowered ring falls back to slot zero.
        slot = (ring_oldest < cap) ? ring_oldest : 0;
        old_len = ring_len[slot];
        ring_removed = ring_removed + GIDX_W'(old_len);
        ring_live = ring_live - LIVE_W'(old_len);
        ring_oldest = (slot + 1 >= cap) ? 0 : slot + 1;
        r.evicted = 1'b1;
      end
      ring_start[slot] = first_ply;
      ring_len[slot] = len_in;
      ring_live = ring_live + LIVE_W'(len_in);
      r.slot = 8'(slot);
      r.evicted_plies = old_len;
      r.live_plies = ring_live;
    end else begin
      r.live_plies = ring_live;
      r.out_of_range = 1'b1;
      if (LIVE_W'(offset) < ring_live) begin
        gidx = ring_removed + GIDX_W'(offset);
        for (i = 0; i < ring_filled && i < SLOTS && r.out_of_range; i++) begin
          delta = gidx - ring_start[i];
          if (delta < GIDX_W'(ring_len[i])) begin
            r.slot = 8'(i);
            r.ply_index = 9'(delta);
            r.out_of_range = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RES_W-1:0]);
      if (ring_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result transfer, slot %0d live_plies %0d",
                   $realtime, got.slot, got.live_plies);
      end else begin
        want = ring_results_due.pop_front();
        check_field("slot", want.slot, got.slot);
        check_field("ply_index", want.ply_index, got.ply_index);
        check_field("evicted", want.evicted, got.evicted);
        check_field("evicted_plies", want.evicted_plies, got.evicted_plies);
        check_field("live_plies", want.live_plies, got.live_plies);
        check_field("out_of_range", want.out_of_range, got.out_of_range);
      end
    end
  end

  // Result side: stall pattern that changes mode now and then, plus a long hold on request.
  initial begin : drive_ready
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_seen;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offers one item and waits for its transfer; bursts end in a random gap.
  task automatic send_item(input logic kind, input logic [PLIES_IN_W-1:0] plies,
                           input logic [OFFSET_W-1:0] offset);
    result_t due;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= IN_DATA_W'({offset, plies});
    do @(posedge clk); while (!s_axis_tready);
    due = ring_apply_item(kind, plies, offset);
    ring_results_due = {ring_results_due, due};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drops the stream and waits until every predicted result has come out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (ring_results_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ring_capacity = value;
  endtask

  task automatic send_random(input int unsigned count, input int unsigned locate_pct);
    logic                  kind;
    logic [PLIES_IN_W-1:0] plies;
    logic [OFFSET_W-1:0]   offset;
    int unsigned           pick;
    repeat (count) begin
      kind = ($urandom_range(0, 99) < locate_pct) ? KIND_LOCATE : KIND_ADD;
      pick = $urandom_range(0, 9);
      case (pick)
        0: plies = '0;
        1: plies = PLIES_IN_W'($urandom_range(MAX_PLIES + 1, 1023));
        2: plies = PLIES_IN_W'(MAX_PLIES);
        default: plies = PLIES_IN_W'($urandom_range(0, MAX_PLIES));
      endcase
      pick = $urandom_range(0, 9);
      if (ring_live != 0 && pick < 7)
        offset = OFFSET_W'($urandom_range(0, ring_live - 1));
      else if (pick == 7)
        offset = (ring_live > 18'h1FFFF) ? '1 : OFFSET_W'(ring_live);
      else
        offset = OFFSET_W'($urandom);
      send_item(kind, plies, offset);
    end
  endtask

  task automatic test_empty_and_extremes();
    send_item(KIND_LOCATE, '0, '0);
    send_item(KIND_LOCATE, '1, '1);
    send_item(KIND_ADD, '0, '1);
    send_item(KIND_LOCATE, '0, '0);
    send_item(KIND_ADD, PLIES_IN_W'(MAX_PLIES), '0);
    send_item(KIND_ADD, '1, '0);
    send_item(KIND_ADD, PLIES_IN_W'(MAX_PLIES + 1), '1);
    send_item(KIND_ADD, 10'd1, '0);
    send_item(KIND_LOCATE, '0, 17'd0);
    send_item(KIND_LOCATE, '0, 17'd511);
    send_item(KIND_LOCATE, '0, 17'd512);
    send_item(KIND_LOCATE, '1, OFFSET_W'(ring_live - 1));
    send_item(KIND_LOCATE, '0, OFFSET_W'(ring_live));
    send_item(KIND_LOCATE, '0, '1);
    wait_idle();
  endtask

  task automatic test_capacity_floor();
    write_capacity('0);
    send_item(KIND_ADD, 10'd100, '0);
    send_item(KIND_ADD, 10'd50, '0);
    // Slots above the shrunken ring still hold the oldest plies, so a stretch of
    // the live range right after them now belongs to no slot.
    send_item(KIND_LOCATE, '0, OFFSET_W'(ring_live - 1));
    send_item(KIND_LOCATE, '0, OFFSET_W'(ring_live - 60));
    send_item(KIND_LOCATE, '0, 17'd0);
    send_random(6, 50);
    write_capacity(9'd1);
    send_random(10, 50);
    wait_idle();
  endtask

  task automatic test_stale_oldest();
    write_capacity(9'd4);
    while (!(ring_filled >= 4 && ring_oldest == 3))
      send_item(KIND_ADD, PLIES_IN_W'($urandom_range(0, MAX_PLIES)), OFFSET_W'($urandom));
    write_capacity(9'd2);
    send_random(12, 40);
    wait_idle();
  endtask

  task automatic test_small_rings();
    repeat (4) begin
      write_capacity(CAP_W'($urandom_range(1, 12)));
      send_random(150, 55);
    end
    wait_idle();
  endtask

  task automatic test_receiver_holdoff();
    @(negedge clk);
    hold_req = ~hold_req;
    send_random(40, 55);
    wait_idle();
  endtask

  task automatic test_full_ring();
    write_capacity(9'd511);
    send_random(300, 45);
    write_capacity(CAP_RESET);
    send_random(200, 55);
    write_capacity(CAP_W'($urandom_range(SLOTS + 1, 510)));
    send_random(150, 55);
    write_capacity(CAP_W'($urandom_range(1, SLOTS)));
    send_random(150, 55);
    wait_idle();
  endtask

  task automatic test_ring_shrink();
    write_capacity(CAP_W'($urandom_range(1, 8)));
    send_random(100, 55);
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_extremes();
    test_capacity_floor();
    test_stale_oldest();
    test_small_rings();
    test_receiver_holdoff();
    test_full_ring();
    test_ring_shrink();
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && ring_results_due.size() == 0)
      $display("** game_ring_ply_locator: PASSED **");
    else
      $display("** game_ring_ply_locator: FAILED **");
    $finish;
  end

endmodule
